// ===== design/stuffed_frame_receiver_defines.svh =====
// Assertion macros for the stuffed frame receiver.
`ifndef STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_DEFINES_SVH

// same-cycle implication, checked on clk, off during reset
`define SFR_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfr check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfr check failed");

`endif

// ===== design/sfr_pkg.sv =====
// Types and constants shared by the stuffed frame receiver modules.
`timescale 1ns / 1ps
package sfr_pkg;

	localparam int unsigned LenW = 17;
	localparam int unsigned IdxW = 16;
	localparam int unsigned AddrW = 5;
	localparam int unsigned TdataW = 48;

	localparam logic [LenW-1:0] LimitLo = 17'd7;
	localparam logic [LenW-1:0] MinFrameLen = 17'd3;
	localparam logic [LenW-1:0] MinPayloadLen = 17'd5;
	localparam logic [7:0] AddrPrimary = 8'h01;
	localparam logic [7:0] AddrSecondary = 8'h03;

	localparam logic [7:0] FlagValueRst = 8'h7E;
	localparam logic [7:0] EscapeValueRst = 8'h7D;
	localparam logic [7:0] FlagCodeRst = 8'h5E;
	localparam logic [7:0] EscapeCodeRst = 8'h5D;
	localparam logic [LenW-1:0] MaxLengthRst = 17'd256;

	typedef enum logic [2:0] {
		REG_FLAG_VALUE = 3'd0,
		REG_ESCAPE_VALUE = 3'd1,
		REG_FLAG_CODE = 3'd2,
		REG_ESCAPE_CODE = 3'd3,
		REG_MAX_LENGTH = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_HUNT = 2'd0,
		MODE_FRAME = 2'd1,
		MODE_ESC = 2'd2,
		MODE_DROP = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_SHORT = 2'd1,
		ST_TRUNC = 2'd2,
		ST_ESC_ERR = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] flag_value;
		logic [7:0] escape_value;
		logic [7:0] flag_code;
		logic [7:0] escape_code;
		logic [LenW-1:0] eff_limit;
	} cfg_t;

	typedef struct packed {
		logic kind;
		logic [7:0] data_byte;
		logic [IdxW-1:0] byte_index;
		logic [LenW-1:0] frame_length;
		status_t status;
		logic header_ok;
		logic payload_ok;
	} res_t;

endpackage

// ===== design/sfr_cfg_regs.sv =====
// APB register bank with limit saturation for the stuffed frame receiver.
`timescale 1ns / 1ps
module sfr_cfg_regs #(
	parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sfr_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output sfr_pkg::cfg_t cfg
);

	localparam logic [sfr_pkg::LenW-1:0] LimitHi = sfr_pkg::LenW'(MAX_FRAME_LIMIT);

	logic [7:0] flag_value_q;
	logic [7:0] escape_value_q;
	logic [7:0] flag_code_q;
	logic [7:0] escape_code_q;
	logic [sfr_pkg::LenW-1:0] max_length_q;
	logic [2:0] idx;
	logic wr_en;

	assign idx = paddr[sfr_pkg::AddrW-1:2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_value_q <= sfr_pkg::FlagValueRst;
			escape_value_q <= sfr_pkg::EscapeValueRst;
			flag_code_q <= sfr_pkg::FlagCodeRst;
			escape_code_q <= sfr_pkg::EscapeCodeRst;
			max_length_q <= sfr_pkg::MaxLengthRst;
		end else if (wr_en) begin
			case (idx)
				sfr_pkg::REG_FLAG_VALUE: flag_value_q <= pwdata[7:0];
				sfr_pkg::REG_ESCAPE_VALUE: escape_value_q <= pwdata[7:0];
				sfr_pkg::REG_FLAG_CODE: flag_code_q <= pwdata[7:0];
				sfr_pkg::REG_ESCAPE_CODE: escape_code_q <= pwdata[7:0];
				sfr_pkg::REG_MAX_LENGTH: max_length_q <= pwdata[sfr_pkg::LenW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			sfr_pkg::REG_FLAG_VALUE: prdata = {24'd0, flag_value_q};
			sfr_pkg::REG_ESCAPE_VALUE: prdata = {24'd0, escape_value_q};
			sfr_pkg::REG_FLAG_CODE: prdata = {24'd0, flag_code_q};
			sfr_pkg::REG_ESCAPE_CODE: prdata = {24'd0, escape_code_q};
			sfr_pkg::REG_MAX_LENGTH: prdata = {15'd0, max_length_q};
			default: prdata = 32'd0;
		endcase
	end

	always_comb begin
		cfg.flag_value = flag_value_q;
		cfg.escape_value = escape_value_q;
		cfg.flag_code = flag_code_q;
		cfg.escape_code = escape_code_q;
		if (max_length_q < sfr_pkg::LimitLo) begin
			cfg.eff_limit = sfr_pkg::LimitLo;
		end else if (max_length_q > LimitHi) begin
			cfg.eff_limit = LimitHi;
		end else begin
			cfg.eff_limit = max_length_q;
		end
	end

endmodule

// ===== design/sfr_deframe.sv =====
// Deframer state and per-byte destuffing, length and check logic.
`timescale 1ns / 1ps
module sfr_deframe (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [7:0] rx_byte,
	input  sfr_pkg::cfg_t cfg,
	output logic res_valid,
	output sfr_pkg::res_t res
);

	sfr_pkg::mode_t mode_q, mode_d;
	logic [sfr_pkg::LenW-1:0] count_q, count_d;
	logic [7:0] addr_q, addr_d;
	logic [7:0] hxor_q, hxor_d;
	logic [7:0] pxor_q, pxor_d;

	logic is_flag;
	logic is_esc;
	logic do_data;
	logic do_end;
	logic end_checks;
	sfr_pkg::status_t end_status;
	logic [7:0] data_val;
	logic [sfr_pkg::LenW-1:0] count_inc;
	logic clear_frame;

	assign is_flag = (rx_byte == cfg.flag_value);
	assign is_esc = (rx_byte == cfg.escape_value);
	assign count_inc = count_q + sfr_pkg::LenW'(1);

	// next mode and action decode
	always_comb begin
		mode_d = mode_q;
		do_data = 1'b0;
		do_end = 1'b0;
		end_checks = 1'b0;
		end_status = sfr_pkg::ST_OK;
		data_val = rx_byte;
		clear_frame = 1'b0;
		case (mode_q)
			sfr_pkg::MODE_HUNT: begin
				if (is_flag) begin
					clear_frame = 1'b1;
					mode_d = sfr_pkg::MODE_FRAME;
				end
			end
			sfr_pkg::MODE_FRAME: begin
				if (is_flag) begin
					do_end = 1'b1;
					if (count_q < sfr_pkg::MinFrameLen) begin
						end_status = sfr_pkg::ST_SHORT;
						clear_frame = 1'b1;
					end else begin
						end_checks = 1'b1;
						mode_d = sfr_pkg::MODE_HUNT;
					end
				end else if (is_esc) begin
					mode_d = sfr_pkg::MODE_ESC;
				end else begin
					do_data = 1'b1;
				end
			end
			sfr_pkg::MODE_ESC: begin
				if (rx_byte == cfg.flag_code) begin
					do_data = 1'b1;
					data_val = cfg.flag_value;
				end else if (rx_byte == cfg.escape_code) begin
					do_data = 1'b1;
					data_val = cfg.escape_value;
				end else begin
					do_end = 1'b1;
					end_status = sfr_pkg::ST_ESC_ERR;
					mode_d = sfr_pkg::MODE_HUNT;
				end
			end
			sfr_pkg::MODE_DROP: begin
				if (is_flag) begin
					do_end = 1'b1;
					end_status = sfr_pkg::ST_TRUNC;
					end_checks = 1'b1;
					mode_d = sfr_pkg::MODE_HUNT;
				end
			end
			default: mode_d = sfr_pkg::MODE_HUNT;
		endcase
		if (do_data) begin
			mode_d = (count_inc >= cfg.eff_limit) ? sfr_pkg::MODE_DROP : sfr_pkg::MODE_FRAME;
		end
	end

	// frame accumulators
	always_comb begin
		count_d = count_q;
		addr_d = addr_q;
		hxor_d = hxor_q;
		pxor_d = pxor_q;
		if (clear_frame) begin
			count_d = '0;
			addr_d = '0;
			hxor_d = '0;
			pxor_d = '0;
		end else if (do_data) begin
			count_d = count_inc;
			if (count_q == '0) begin
				addr_d = data_val;
				hxor_d = data_val;
			end else if (count_q < sfr_pkg::MinFrameLen) begin
				hxor_d = hxor_q ^ data_val;
			end else begin
				pxor_d = pxor_q ^ data_val;
			end
		end
	end

	// result fields
	always_comb begin
		res_valid = do_data || do_end;
		res = '0;
		if (do_data) begin
			res.data_byte = data_val;
			res.byte_index = count_q[sfr_pkg::IdxW-1:0];
		end else begin
			res.kind = 1'b1;
			res.frame_length = count_q;
			res.status = end_status;
			res.header_ok = end_checks && (count_q >= sfr_pkg::MinFrameLen)
				&& ((addr_q == sfr_pkg::AddrPrimary) || (addr_q == sfr_pkg::AddrSecondary))
				&& (hxor_q == 8'd0);
			res.payload_ok = end_checks && (count_q >= sfr_pkg::MinPayloadLen)
				&& (pxor_q == 8'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= sfr_pkg::MODE_HUNT;
			count_q <= '0;
			addr_q <= '0;
			hxor_q <= '0;
			pxor_q <= '0;
		end else if (step) begin
			mode_q <= mode_d;
			count_q <= count_d;
			addr_q <= addr_d;
			hxor_q <= hxor_d;
			pxor_q <= pxor_d;
		end
	end

endmodule

// ===== design/stuffed_frame_receiver.sv =====
// Top level of the stuffed frame receiver: input stage, deframer, result register.
//
//  port group | dir | beat contents
//  s_t*       | in  | tdata[7:0] rx_byte
//  m_t*       | out | tuser kind; tdata data_byte..payload_ok, 48 bits
//  p*         | cfg | APB, regs at 4*i: flag, escape, flag code, escape code, max_length
//
// One byte per cycle sustained while the result register drains; a byte is held in the
// input stage and its result, if any, is loaded into the result register when it advances.
// The input stage advances when the result register is empty or being drained.
// Reset clears frame state to hunting and loads register defaults.
`timescale 1ns / 1ps
`include "stuffed_frame_receiver_defines.svh"
module stuffed_frame_receiver #(
	parameter int unsigned MAX_FRAME_LIMIT = 65536
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [sfr_pkg::AddrW-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic [7:0] s_tdata,   // [7:0] rx_byte
	output logic m_tvalid,
	input  logic m_tready,
	// [7:0] data_byte, [23:8] byte_index, [40:24] frame_length, [42:41] status,
	// [43] header_ok, [44] payload_ok, [47:45] zero
	output logic [sfr_pkg::TdataW-1:0] m_tdata,
	output logic m_tuser          // [0] kind
);

	sfr_pkg::cfg_t cfg;
	sfr_pkg::res_t res;
	logic res_valid;
	logic valid_s1;
	logic [7:0] byte_s1;
	logic advance;

	assign pready = 1'b1;

	sfr_cfg_regs #(
		.MAX_FRAME_LIMIT(MAX_FRAME_LIMIT)
	) u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.cfg(cfg)
	);

	assign advance = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	sfr_deframe u_deframe (
		.clk(clk),
		.arst_n(arst_n),
		.step(advance),
		.rx_byte(byte_s1),
		.cfg(cfg),
		.res_valid(res_valid),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance && res_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			m_tuser <= res.kind;
			m_tdata <= {3'd0, res.payload_ok, res.header_ok, res.status,
				res.frame_length, res.byte_index, res.data_byte};
		end
	end

	`SFR_ASSERT_IMPL(a_end_no_data, m_tvalid && m_tuser, m_tdata[23:0] == 24'd0)
	`SFR_ASSERT_IMPL(a_data_no_report, m_tvalid && !m_tuser, m_tdata[47:24] == 24'd0)
	`SFR_ASSERT_IMPL(a_short_len,
		m_tvalid && m_tuser && (m_tdata[42:41] == sfr_pkg::ST_SHORT),
		m_tdata[40:24] < sfr_pkg::MinFrameLen)
	`SFR_ASSERT_NEXT(a_result_loaded, advance && res_valid, m_tvalid)

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the stuffed frame receiver: random framed traffic, APB setup.
`timescale 1ns / 1ps
module tb;

	localparam int unsigned StallLimit = 2000;
	localparam logic [sfr_pkg::LenW-1:0] FrameCap = 17'd65536;
	localparam logic [sfr_pkg::AddrW-1:0] SpareAddr = 5'd20;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [sfr_pkg::AddrW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [sfr_pkg::TdataW-1:0] m_tdata;
	logic m_tuser;

	stuffed_frame_receiver dut (.*);

	always #10 clk = ~clk;

	// register mirror
	logic [7:0] cfg_flag = sfr_pkg::FlagValueRst;
	logic [7:0] cfg_esc = sfr_pkg::EscapeValueRst;
	logic [7:0] cfg_fcode = sfr_pkg::FlagCodeRst;
	logic [7:0] cfg_ecode = sfr_pkg::EscapeCodeRst;
	logic [sfr_pkg::LenW-1:0] cfg_maxlen = sfr_pkg::MaxLengthRst;

	// deframer state
	sfr_pkg::mode_t fr_mode = sfr_pkg::MODE_HUNT;
	logic [sfr_pkg::LenW-1:0] fr_count = '0;
	logic [7:0] fr_addr = '0;
	logic [7:0] fr_hxor = '0;
	logic [7:0] fr_pxor = '0;

	logic [7:0] line_bytes[$];
	sfr_pkg::res_t due_results[$];

	int n_errors = 0;
	int n_beats = 0;
	int n_bytes_sent = 0;
	int n_settings = 1;
	int status_seen[4] = '{0, 0, 0, 0};
	int in_gap = 0;
	int out_gap = 0;
	int idle_cycles = 0;
	logic in_acc = 1'b0;
	logic calm = 1'b0;

	function automatic logic [sfr_pkg::LenW-1:0] limit_now();
		if (cfg_maxlen < sfr_pkg::LimitLo) return sfr_pkg::LimitLo;
		if (cfg_maxlen > FrameCap) return FrameCap;
		return cfg_maxlen;
	endfunction

	task automatic restart_frame();
		fr_count = '0;
		fr_addr = '0;
		fr_hxor = '0;
		fr_pxor = '0;
	endtask

	task automatic keep_byte(input logic [7:0] b);
		sfr_pkg::res_t r;
		if (fr_count == 0) begin
			fr_addr = b;
			fr_hxor = b;
		end else if (fr_count < sfr_pkg::MinFrameLen) begin
			fr_hxor ^= b;
		end else begin
			fr_pxor ^= b;
		end
		r = '0;
		r.data_byte = b;
		r.byte_index = fr_count[sfr_pkg::IdxW-1:0];
		due_results.push_back(r);
		fr_count = fr_count + 1'b1;
		if (fr_count >= limit_now()) fr_mode = sfr_pkg::MODE_DROP;
		else fr_mode = sfr_pkg::MODE_FRAME;
	endtask

	task automatic close_frame(input sfr_pkg::status_t st, input logic checks);
		sfr_pkg::res_t r;
		r = '0;
		r.kind = 1'b1;
		r.frame_length = fr_count;
		r.status = st;
		r.header_ok = checks && fr_count >= sfr_pkg::MinFrameLen &&
			(fr_addr == sfr_pkg::AddrPrimary || fr_addr == sfr_pkg::AddrSecondary) &&
			fr_hxor == 8'h00;
		r.payload_ok = checks && fr_count >= sfr_pkg::MinPayloadLen && fr_pxor == 8'h00;
		due_results.push_back(r);
	endtask

	task automatic deframe_byte(input logic [7:0] b);
		case (fr_mode)
			sfr_pkg::MODE_HUNT: begin
				if (b == cfg_flag) begin
					restart_frame();
					fr_mode = sfr_pkg::MODE_FRAME;
				end
			end
			sfr_pkg::MODE_FRAME: begin
				if (b == cfg_flag) begin
					if (fr_count < sfr_pkg::MinFrameLen) begin
						close_frame(sfr_pkg::ST_SHORT, 1'b0);
						restart_frame();
					end else begin
						close_frame(sfr_pkg::ST_OK, 1'b1);
						fr_mode = sfr_pkg::MODE_HUNT;
					end
				end else if (b == cfg_esc) begin
					fr_mode = sfr_pkg::MODE_ESC;
				end else begin
					keep_byte(b);
				end
			end
			sfr_pkg::MODE_ESC: begin
				if (b == cfg_fcode) keep_byte(cfg_flag);
				else if (b == cfg_ecode) keep_byte(cfg_esc);
				else begin
					close_frame(sfr_pkg::ST_ESC_ERR, 1'b0);
					fr_mode = sfr_pkg::MODE_HUNT;
				end
			end
			default: begin
				if (b == cfg_flag) begin
					close_frame(sfr_pkg::ST_TRUNC, 1'b1);
					fr_mode = sfr_pkg::MODE_HUNT;
				end
			end
		endcase
	endtask

	task automatic send_stuffed(input logic [7:0] b);
		if (b == cfg_flag) begin
			line_bytes.push_back(cfg_esc);
			line_bytes.push_back(cfg_fcode);
		end else if (b == cfg_esc) begin
			line_bytes.push_back(cfg_esc);
			line_bytes.push_back(cfg_ecode);
		end else begin
			line_bytes.push_back(b);
		end
	endtask

	// header of address, control, check; payload closed by an xor check byte
	task automatic send_frame(input int len);
		logic [7:0] a;
		logic [7:0] c;
		logic [7:0] chk;
		logic [7:0] b;
		if ($urandom_range(0, 3) == 0) a = 8'($urandom);
		else if ($urandom_range(0, 1) == 0) a = sfr_pkg::AddrPrimary;
		else a = sfr_pkg::AddrSecondary;
		c = 8'($urandom);
		chk = 8'h00;
		line_bytes.push_back(cfg_flag);
		for (int k = 0; k < len; k++) begin
			if (k == 0) b = a;
			else if (k == 1) b = c;
			else if (k == 2) b = ($urandom_range(0, 4) == 0) ? 8'($urandom) : a ^ c;
			else if (k == len - 1 && $urandom_range(0, 4) != 0) b = chk;
			else b = 8'($urandom);
			if (k >= 3) chk ^= b;
			send_stuffed(b);
		end
		line_bytes.push_back(cfg_flag);
	endtask

	task automatic send_escape_error();
		int n;
		n = $urandom_range(0, 4);
		line_bytes.push_back(cfg_flag);
		for (int k = 0; k < n; k++) send_stuffed(8'($urandom));
		line_bytes.push_back(cfg_esc);
		line_bytes.push_back(($urandom_range(0, 2) == 0) ? cfg_flag : 8'($urandom));
	endtask

	task automatic send_noise(input int n);
		for (int k = 0; k < n; k++) begin
			case ($urandom_range(0, 5))
				0: line_bytes.push_back(cfg_flag);
				1: line_bytes.push_back(cfg_esc);
				2: line_bytes.push_back(cfg_fcode);
				3: line_bytes.push_back(cfg_ecode);
				default: line_bytes.push_back(8'($urandom));
			endcase
		end
	endtask

	task automatic fill_random(input int target);
		int start;
		int pick;
		int lim;
		start = line_bytes.size();
		lim = int'(limit_now());
		while (line_bytes.size() - start < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) send_frame($urandom_range(3, 12));
			else if (pick < 65) send_frame($urandom_range(0, 2));
			else if (pick < 75) send_frame($urandom_range(13, 40));
			else if (pick < 83) begin
				if (lim <= 64) send_frame($urandom_range(lim - 1, lim + 4));
				else send_frame($urandom_range(3, 12));
			end else if (pick < 91) send_escape_error();
			else send_noise($urandom_range(1, 6));
		end
	endtask

	task automatic drain();
		do begin
			@(posedge clk);
			#1;
		end while (line_bytes.size() != 0 || s_tvalid || due_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(input logic [sfr_pkg::AddrW-1:0] addr, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// upper bits carry junk that the block must ignore
	task automatic set_reg(input sfr_pkg::reg_idx_t r, input logic [sfr_pkg::LenW-1:0] v);
		logic [31:0] word;
		word = $urandom;
		if (r == sfr_pkg::REG_MAX_LENGTH) word[sfr_pkg::LenW-1:0] = v;
		else word[7:0] = v[7:0];
		apb_write({r, 2'b00}, word);
		case (r)
			sfr_pkg::REG_FLAG_VALUE: cfg_flag = v[7:0];
			sfr_pkg::REG_ESCAPE_VALUE: cfg_esc = v[7:0];
			sfr_pkg::REG_FLAG_CODE: cfg_fcode = v[7:0];
			sfr_pkg::REG_ESCAPE_CODE: cfg_ecode = v[7:0];
			default: cfg_maxlen = v;
		endcase
	endtask

	task automatic program_setting(input logic [7:0] f, input logic [7:0] e,
			input logic [7:0] fc, input logic [7:0] ec,
			input logic [sfr_pkg::LenW-1:0] ml);
		set_reg(sfr_pkg::REG_FLAG_VALUE, {9'd0, f});
		set_reg(sfr_pkg::REG_ESCAPE_VALUE, {9'd0, e});
		set_reg(sfr_pkg::REG_FLAG_CODE, {9'd0, fc});
		set_reg(sfr_pkg::REG_ESCAPE_CODE, {9'd0, ec});
		set_reg(sfr_pkg::REG_MAX_LENGTH, ml);
		n_settings++;
	endtask

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || in_acc) begin
				if (in_gap > 0) begin
					in_gap <= in_gap - 1;
					s_tvalid <= 1'b0;
				end else if (!calm && $urandom_range(0, 15) == 0) begin
					in_gap <= $urandom_range(0, 8);
					s_tvalid <= 1'b0;
				end else if (line_bytes.size() > 0) begin
					s_tdata <= line_bytes.pop_front();
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_gap > 0) begin
				out_gap <= out_gap - 1;
				m_tready <= 1'b0;
			end else if (!calm && $urandom_range(0, 11) == 0) begin
				out_gap <= $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// monitor, checker and watchdog
	always @(posedge clk) begin
		sfr_pkg::res_t got;
		sfr_pkg::res_t want;
		if (arst_n) begin
			in_acc = s_tvalid && s_tready;
			if (m_tvalid && m_tready) begin
				got.kind = m_tuser;
				got.data_byte = m_tdata[7:0];
				got.byte_index = m_tdata[23:8];
				got.frame_length = m_tdata[40:24];
				got.status = sfr_pkg::status_t'(m_tdata[42:41]);
				got.header_ok = m_tdata[43];
				got.payload_ok = m_tdata[44];
				if (due_results.size() == 0) begin
					n_errors++;
					if (n_errors <= 10)
						$display("unexpected beat: kind %0d tdata %h", m_tuser, m_tdata);
				end else begin
					want = due_results.pop_front();
					n_beats++;
					if (want.kind) status_seen[want.status]++;
					if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
							got.byte_index !== want.byte_index ||
							got.frame_length !== want.frame_length ||
							got.status !== want.status || got.header_ok !== want.header_ok ||
							got.payload_ok !== want.payload_ok) begin
						n_errors++;
						if (n_errors <= 10) begin
							$display("mismatch at beat %0d: kind/byte/idx/len/st/hok/pok", n_beats);
							$display("  expected %0d %h %0d %0d %0d %0d %0d", want.kind,
								want.data_byte, want.byte_index, want.frame_length,
								want.status, want.header_ok, want.payload_ok);
							$display("  actual   %0d %h %0d %0d %0d %0d %0d", got.kind,
								got.data_byte, got.byte_index, got.frame_length,
								got.status, got.header_ok, got.payload_ok);
						end
					end
				end
			end
			if (in_acc) begin
				n_bytes_sent++;
				deframe_byte(s_tdata);
			end
			if (in_acc || (m_tvalid && m_tready) || psel) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("watchdog: no beat for %0d cycles, %0d results outstanding",
					idle_cycles, due_results.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		logic [7:0] opening [25];
		logic [7:0] f;
		logic [7:0] e;
		opening = '{8'h00, 8'hFF, 8'h7E, 8'h7E, 8'h01, 8'h03, 8'h02, 8'h7E,
			8'h7E, 8'h03, 8'hFF, 8'hFC, 8'h7D, 8'h5E, 8'h7D, 8'h5D, 8'h03, 8'h7E,
			8'h7E, 8'hAA, 8'h7D, 8'h11, 8'h7E, 8'h7D, 8'h7E};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// defaults: short, good, stuffed, escape errors
		foreach (opening[i]) line_bytes.push_back(opening[i]);
		fill_random(150);
		drain();

		// smallest limit, extreme codes
		program_setting(8'h00, 8'hFF, 8'h00, 8'hFF, 17'd0);
		send_frame(6);
		send_frame(7);
		send_frame(10);
		fill_random(150);
		drain();

		apb_write(SpareAddr, $urandom);
		program_setting(8'hFF, 8'h00, 8'hFF, 8'h00, 17'h1FFFF);
		fill_random(150);
		drain();

		f = $urandom;
		do e = $urandom; while (e == f);
		program_setting(f, e, 8'($urandom), 8'($urandom), 17'($urandom_range(8, 40)));
		fill_random(150);
		drain();

		f = $urandom;
		e = ($urandom_range(0, 3) == 0) ? f : 8'($urandom);
		program_setting(f, e, 8'($urandom), 8'($urandom), 17'd7);
		fill_random(150);
		drain();

		// no idling from here; full-size length limit
		calm = 1'b1;
		program_setting(sfr_pkg::FlagValueRst, sfr_pkg::EscapeValueRst,
			sfr_pkg::FlagCodeRst, sfr_pkg::EscapeCodeRst, FrameCap);
		fill_random(150);
		drain();

		$display("%0d line bytes in, %0d result beats checked, %0d register settings",
			n_bytes_sent, n_beats, n_settings);
		$display("end reports: %0d ok, %0d short, %0d truncated, %0d escape error",
			status_seen[sfr_pkg::ST_OK], status_seen[sfr_pkg::ST_SHORT],
			status_seen[sfr_pkg::ST_TRUNC], status_seen[sfr_pkg::ST_ESC_ERR]);
		if (n_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("FAILURE");
		end
		$finish;
	end

endmodule
